// ----- sv/mf3_pkg.sv -----
package mf3_pkg;

    // Field widths of the stream words
    localparam int PIX_W      = 8;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 11;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    // One window column, sorted low to high
    typedef struct packed {
        t_pix hi;
        t_pix mid;
        t_pix lo;
    } t_col3;

    // Full 3x3 window as three sorted columns, c0 oldest
    typedef struct packed {
        t_col3 c2;
        t_col3 c1;
        t_col3 c0;
    } t_win;

    // Line store entry: pixel two rows up and one row up
    typedef struct packed {
        t_pix up2;
        t_pix up1;
    } t_line;

    // Per-pixel tag carried down the pipeline
    typedef struct packed {
        logic                 med;
        logic                 brd;
        t_pix                 pix;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } t_tag;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Three compare-exchange steps
    function automatic t_col3 sort3(input t_pix a, input t_pix b, input t_pix c);
        t_pix  l0;
        t_pix  h0;
        t_pix  h1;
        t_col3 res;
        l0      = min2(a, b);
        h0      = max2(a, b);
        h1      = max2(h0, c);
        res.hi  = h1;
        res.lo  = min2(l0, min2(h0, c));
        res.mid = max2(l0, min2(h0, c));
        return res;
    endfunction

endpackage

// ----- sv/mf3_window.sv -----
module mf3_window #(
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,      // word accepted upstream
    input  logic [AW-1:0]  i_rd_addr,
    input  mf3_pkg::t_tag  i_tag,
    input  logic           i_clear,      // frame restart
    input  logic           i_next_ready,
    output logic           o_ready,
    output logic           o_valid,
    output mf3_pkg::t_win  o_win,
    output mf3_pkg::t_tag  o_tag
);
    import mf3_pkg::*;

    // Two line stores packed into one memory
    t_line r_mem [DEPTH];

    logic          r_valid;
    t_tag          r_tag;
    logic [AW-1:0] r_addr;
    t_line         r_rd_data;
    logic          r_fwd;
    t_line         r_fwd_data;
    t_col3         r_win [2];

    logic  move;
    t_line line_now;
    t_line wr_data;
    t_col3 new_col;

    assign move     = r_valid && i_next_ready;
    assign o_ready  = !r_valid || i_next_ready;
    assign line_now = r_fwd ? r_fwd_data : r_rd_data;

    // Shift the column down one row in the line stores
    always_comb begin
        wr_data.up2 = line_now.up1;
        wr_data.up1 = r_tag.pix;
    end

    assign new_col = sort3(line_now.up2, line_now.up1, r_tag.pix);

    // Memory: read on accept, write back as the word leaves this stage
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (move) begin
            r_mem[r_addr] <= wr_data;
        end
    end

    // Forward the write that lands on the entry being read (one-pixel rows)
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd      <= move && (r_addr == i_rd_addr);
            r_fwd_data <= wr_data;
            r_tag      <= i_tag;
            r_addr     <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_rd_en;
        end
    end

    // Window of the two previous columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
        end else if (move) begin
            r_win[0] <= r_win[1];
            r_win[1] <= new_col;
        end
    end

    assign o_valid  = r_valid;
    assign o_tag    = r_tag;
    assign o_win.c0 = r_win[0];
    assign o_win.c1 = r_win[1];
    assign o_win.c2 = new_col;

endmodule

// ----- sv/mf3_median.sv -----
module mf3_median (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mf3_pkg::t_win i_win,
    input  mf3_pkg::t_tag i_tag,
    input  logic          i_next_ready,
    output logic          o_ready,
    output logic          o_valid,
    output mf3_pkg::t_pix o_median,
    output mf3_pkg::t_tag o_tag
);
    import mf3_pkg::*;

    logic r_c_valid;
    t_pix r_c_lo;
    t_pix r_c_mid;
    t_pix r_c_hi;
    t_tag r_c_tag;

    logic r_d_valid;
    t_pix r_d_med;
    t_tag r_d_tag;

    logic c_ready;
    logic d_ready;

    assign d_ready = !r_d_valid || i_next_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign o_ready = c_ready;

    // Stage C: max of lows, median of mids, min of highs
    always_ff @(posedge i_clk) begin
        if (c_ready && i_valid) begin
            r_c_lo  <= max3(i_win.c0.lo, i_win.c1.lo, i_win.c2.lo);
            r_c_mid <= med3(i_win.c0.mid, i_win.c1.mid, i_win.c2.mid);
            r_c_hi  <= min3(i_win.c0.hi, i_win.c1.hi, i_win.c2.hi);
            r_c_tag <= i_tag;
        end
    end

    // Stage D: median of the three candidates
    always_ff @(posedge i_clk) begin
        if (d_ready && r_c_valid) begin
            r_d_med <= med3(r_c_lo, r_c_mid, r_c_hi);
            r_d_tag <= r_c_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (c_ready) begin
                r_c_valid <= i_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    assign o_valid  = r_d_valid;
    assign o_median = r_d_med;
    assign o_tag    = r_d_tag;

endmodule

// ----- sv/mf3_emit.sv -----
module mf3_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  mf3_pkg::t_tag                     i_tag,
    input  mf3_pkg::t_pix                     i_median,
    output logic                              o_ready,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output mf3_pkg::t_pix                     o_pixel,
    output logic [mf3_pkg::OUT_ROW_W-1:0]     o_row,
    output logic [mf3_pkg::OUT_COL_W-1:0]     o_col,
    output logic                              o_last
);
    import mf3_pkg::*;

    logic                 r_valid;
    logic                 r_med_pend;
    logic                 r_brd_pend;
    t_pix                 r_median;
    t_pix                 r_pix;
    logic [OUT_ROW_W-1:0] r_row;
    logic [OUT_COL_W-1:0] r_col;
    logic [OUT_ROW_W-1:0] r_med_row;
    logic [OUT_COL_W-1:0] r_med_col;

    logic last_now;
    logic done;
    logic load;

    // Median word goes first, border word second
    assign last_now = !(r_med_pend && r_brd_pend);
    assign done     = r_valid && i_tready && last_now;
    assign o_ready  = !r_valid || done;
    assign load     = o_ready && i_valid && (i_tag.med || i_tag.brd);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_median  <= i_median;
            r_pix     <= i_tag.pix;
            r_row     <= i_tag.row;
            r_col     <= i_tag.col;
            r_med_row <= i_tag.row - 1'b1;
            r_med_col <= i_tag.col - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_med_pend <= 1'b0;
            r_brd_pend <= 1'b0;
        end else if (load) begin
            r_valid    <= 1'b1;
            r_med_pend <= i_tag.med;
            r_brd_pend <= i_tag.brd;
        end else if (done) begin
            r_valid    <= 1'b0;
            r_med_pend <= 1'b0;
            r_brd_pend <= 1'b0;
        end else if (r_valid && i_tready) begin
            r_med_pend <= 1'b0;
        end
    end

    assign o_tvalid = r_valid;
    assign o_pixel  = r_med_pend ? r_median  : r_pix;
    assign o_row    = r_med_pend ? r_med_row : r_row;
    assign o_col    = r_med_pend ? r_med_col : r_col;
    assign o_last   = last_now;

endmodule

// ----- sv/median_filter_3x3_stream_core.sv -----
// Path: an input word passes the window, median C, median D and emit registers.
// Throughput: one pixel per cycle unless the output stalls; a pixel with both a median
//   and a border word holds the single output register for both (last row or column).
// Reset: position 0/0, size 640 x 480, window cleared; the line memory is not
//   initialized and needs no clearing pass. A size write also restarts the frame.
module median_filter_3x3_stream_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [mf3_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // [7:0] pixel_in
    // Output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [mf3_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,  // [7:0] pixel_out,
                                                               // [19:8] out_row,
                                                               // [30:20] out_col
    output logic                              o_m_axis_tlast,  // last_of_item
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mf3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // Last valid index for a size value, zero acting as one
    function automatic int unsigned last_index(input int unsigned v, input int unsigned lim);
        if (v == 0) begin
            return 0;
        end
        if (v > lim) begin
            return lim - 1;
        end
        return v - 1;
    endfunction

    localparam logic [CW-1:0] LAST_COL_RST = CW'(last_index(640, MAX_WIDTH));
    localparam logic [RW-1:0] LAST_ROW_RST = RW'(last_index(480, MAX_HEIGHT));

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;

    logic cfg_wr;
    logic cfg_hit;
    logic accept;
    t_tag in_tag;

    logic win_ready;
    logic win_valid;
    t_win win;
    t_tag win_tag;

    logic med_ready;
    logic med_valid;
    t_pix med_pix;
    t_tag med_tag;

    logic                 emit_ready;
    t_pix                 out_pix;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Register decode
    always_comb begin
        unique case (t_cfg_idx'(i_cfg_index))
            CFG_IMAGE_WIDTH:  cfg_hit = cfg_wr;
            CFG_IMAGE_HEIGHT: cfg_hit = cfg_wr;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= LAST_COL_RST;
            r_last_row <= LAST_ROW_RST;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    r_last_col <= CW'(last_index(32'(i_cfg_data[WIDTH_REG_W-1:0]),
                                                 MAX_WIDTH));
                end
                CFG_IMAGE_HEIGHT: begin
                    r_last_row <= RW'(last_index(32'(i_cfg_data[HEIGHT_REG_W-1:0]),
                                                 MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = win_ready;
    assign accept          = i_s_axis_tvalid && win_ready;

    // Classify the arriving pixel
    always_comb begin
        in_tag.med = (r_row >= RW'(2)) && (r_col >= CW'(2));
        in_tag.brd = (r_row == '0) || (r_col == '0) ||
                     (r_row == r_last_row) || (r_col == r_last_col);
        in_tag.pix = i_s_axis_tdata[PIX_W-1:0];
        in_tag.row = OUT_ROW_W'(r_row);
        in_tag.col = OUT_COL_W'(r_col);
    end

    // Raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (r_col == r_last_col) begin
                r_col <= '0;
                r_row <= (r_row == r_last_row) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    mf3_window #(
        .DEPTH (MAX_WIDTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (accept),
        .i_rd_addr    (r_col),
        .i_tag        (in_tag),
        .i_clear      (cfg_hit),
        .i_next_ready (med_ready),
        .o_ready      (win_ready),
        .o_valid      (win_valid),
        .o_win        (win),
        .o_tag        (win_tag)
    );

    mf3_median u_median (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (win_valid),
        .i_win        (win),
        .i_tag        (win_tag),
        .i_next_ready (emit_ready),
        .o_ready      (med_ready),
        .o_valid      (med_valid),
        .o_median     (med_pix),
        .o_tag        (med_tag)
    );

    mf3_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (med_valid),
        .i_tag    (med_tag),
        .i_median (med_pix),
        .o_ready  (emit_ready),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_pixel  (out_pix),
        .o_row    (out_row),
        .o_col    (out_col),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_col, out_row, out_pix};

endmodule
